// File: src/tile_set_membership_assert.svh
// Assertion macros used by the tile set membership datapath.
`ifndef TILE_SET_MEMBERSHIP_ASSERT_SVH
`define TILE_SET_MEMBERSHIP_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define TSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TSM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/tsm_pkg.sv
// Package with sizes, payload types, codes and control structs of the tile set.
`default_nettype none

package tsm_pkg;

    // Storage and coordinate sizes
    localparam int TABLE_DEPTH = 1024;
    localparam int COORD_BITS  = 20;
    localparam int ZOOM_W      = 5;
    localparam int KEY_W       = 2 * COORD_BITS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = ZOOM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ZOOM = 1'd1;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_ZOOM  = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;
    localparam status_t STATUS_FULL  = 2'd3;

    // Input transaction
    typedef struct packed {
        logic                  operation;
        logic [ZOOM_W-1:0]     zoom;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } tsm_in_t;

    // Output transaction
    typedef struct packed {
        logic    found;
        status_t status;
    } tsm_out_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    search_init;
        logic    search_rd;
        logic    search_upd;
        logic    shift_init;
        logic    shift_rd;
        logic    shift_wr;
        logic    insert;
        logic    res_load;
        logic    res_found;
        status_t res_status;
    } tsm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_query;
        logic enabled;
        logic zoom_bad;
        logic range_bad;
        logic search_more;
        logic hit;
        logic full;
        logic shift_more;
        logic out_free;
    } tsm_stat_t;

endpackage

`default_nettype wire

// File: src/tile_set_membership.sv
// Top level of the tile set membership table: controller plus datapath.
// Sequence: a query or an in-range add binary-searches the n stored tiles, each step a probe
// read (S_SEARCH) and a compare (S_CMP) on the table RAM; storing a new tile at position p
// first shifts the entries from p up by one; an add refused for zoom or range, or any
// transaction while disabled, goes from the check straight to the result. Throughput: one transaction at a time.
// Reset: table empty, tile count 0, enable 0, base_zoom 14; no clearing pass is needed.
`default_nettype none

module tile_set_membership (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tsm_pkg::tsm_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tsm_pkg::tsm_out_t                  out_data,
    input  wire logic                          cfg_we,
    input  wire logic [tsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsm_pkg::CFG_W-1:0]     cfg_data
);

    tsm_pkg::tsm_cmd_t  cmd;
    tsm_pkg::tsm_stat_t stat;

    tsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: src/tsm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one word each per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/tsm_dp.sv
// Datapath: item and config registers, search bounds, shift index, table RAM, result.
`default_nettype none
`include "tile_set_membership_assert.svh"

module tsm_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tsm_pkg::tsm_in_t              in_data,
    output tsm_pkg::tsm_out_t                  out_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          cfg_we,
    input  wire logic [tsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tsm_pkg::CFG_W-1:0]     cfg_data,
    input  wire tsm_pkg::tsm_cmd_t             cmd,
    output tsm_pkg::tsm_stat_t                 stat
);

    tsm_pkg::tsm_in_t                  item_reg;
    logic                              enable_reg;
    logic [tsm_pkg::ZOOM_W-1:0]        base_zoom_reg;
    logic [tsm_pkg::CNT_W-1:0]         count_reg;
    logic [tsm_pkg::CNT_W-1:0]         count_next;
    logic [tsm_pkg::CNT_W-1:0]         lo_reg;
    logic [tsm_pkg::CNT_W-1:0]         lo_next;
    logic [tsm_pkg::CNT_W-1:0]         hi_reg;
    logic [tsm_pkg::CNT_W-1:0]         hi_next;
    logic [tsm_pkg::CNT_W-1:0]         idx_reg;
    logic [tsm_pkg::CNT_W-1:0]         idx_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              out_valid_reg;
    tsm_pkg::tsm_out_t                 out_data_reg;

    logic [tsm_pkg::KEY_W-1:0]         key;
    logic [tsm_pkg::CNT_W:0]           mid_sum;
    logic [tsm_pkg::CNT_W-1:0]         mid;
    logic [tsm_pkg::CNT_W-1:0]         idx_dec;
    logic                              ram_wr_en;
    logic [tsm_pkg::ADDR_W-1:0]        ram_wr_addr;
    logic [tsm_pkg::KEY_W-1:0]         ram_wr_data;
    logic                              ram_rd_en;
    logic [tsm_pkg::ADDR_W-1:0]        ram_rd_addr;
    logic [tsm_pkg::KEY_W-1:0]         ram_rd_data;

    // Form the sort key and the search midpoint
    assign key     = {item_reg.x, item_reg.y};
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[tsm_pkg::CNT_W:1];
    assign idx_dec = idx_reg - tsm_pkg::CNT_W'(1);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            base_zoom_reg <= tsm_pkg::ZOOM_W'(14);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsm_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                tsm_pkg::CFG_BASE_ZOOM: base_zoom_reg <= cfg_data[tsm_pkg::ZOOM_W-1:0];
                default:                ;
            endcase
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    // Advance search bounds, shift index and hit flag
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        hit_next   = hit_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.search_init)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            hit_next = 1'b0;
        end
        if (cmd.search_upd)
        begin
            if (ram_rd_data < key)
            begin
                lo_next = mid + tsm_pkg::CNT_W'(1);
            end
            else
            begin
                hi_next = mid;
            end
            if (ram_rd_data == key)
            begin
                hit_next = 1'b1;
            end
        end
        if (cmd.shift_init)
        begin
            idx_next = count_reg;
        end
        if (cmd.shift_wr)
        begin
            idx_next = idx_dec;
        end
        if (cmd.insert)
        begin
            count_next = count_reg + tsm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    // Steer RAM ports: probe or shift read, shift or insert write
    always_comb
    begin
        ram_rd_en   = cmd.search_rd || cmd.shift_rd;
        ram_rd_addr = cmd.shift_rd ? idx_dec[tsm_pkg::ADDR_W-1:0]
                                   : mid[tsm_pkg::ADDR_W-1:0];
        ram_wr_en   = cmd.shift_wr || cmd.insert;
        ram_wr_addr = cmd.insert ? lo_reg[tsm_pkg::ADDR_W-1:0]
                                 : idx_reg[tsm_pkg::ADDR_W-1:0];
        ram_wr_data = cmd.insert ? key : ram_rd_data;
    end

    tsm_ram #(
        .WIDTH (tsm_pkg::KEY_W),
        .DEPTH (tsm_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Hold the result until the output transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data_reg.found  <= cmd.res_found;
            out_data_reg.status <= cmd.res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Report conditions to the controller
    always_comb
    begin
        stat.is_query    = (item_reg.operation == tsm_pkg::OP_QUERY);
        stat.enabled     = enable_reg;
        stat.zoom_bad    = (item_reg.zoom != base_zoom_reg);
        if (base_zoom_reg >= tsm_pkg::ZOOM_W'(tsm_pkg::COORD_BITS))
        begin
            stat.range_bad = 1'b0;
        end
        else
        begin
            stat.range_bad = ((item_reg.x >> base_zoom_reg) != '0)
                          || ((item_reg.y >> base_zoom_reg) != '0);
        end
        stat.search_more = (lo_reg < hi_reg);
        stat.hit         = hit_reg;
        stat.full        = (count_reg >= tsm_pkg::CNT_W'(tsm_pkg::TABLE_DEPTH));
        stat.shift_more  = (idx_reg > lo_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Checks
    `TSM_ASSERT(a_count_bound, count_reg <= tsm_pkg::CNT_W'(tsm_pkg::TABLE_DEPTH), "tile count over depth")
    `TSM_ASSERT_IMP(a_insert_ok, cmd.insert, !hit_reg && count_reg < tsm_pkg::CNT_W'(tsm_pkg::TABLE_DEPTH), "insert of stored tile or into full table")
    `TSM_ASSERT_IMP(a_count_step, count_reg != $past(count_reg), $past(cmd.insert), "tile count changed without insert")
    `TSM_ASSERT_IMP(a_res_slot, cmd.res_load, !out_valid_reg || out_ready, "result overwrites pending output")
    `TSM_ASSERT_IMP(a_shift_order, cmd.insert, idx_reg == lo_reg, "insert before shift finished")

endmodule

`default_nettype wire

// File: src/tsm_ctrl.sv
// Controller: sequences checks, binary search, shift, insert and result delivery.
`default_nettype none

module tsm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tsm_pkg::tsm_stat_t stat,
    output tsm_pkg::tsm_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SEARCH   = 3'd2;
    localparam logic [2:0] S_CMP      = 3'd3;
    localparam logic [2:0] S_DECIDE   = 3'd4;
    localparam logic [2:0] S_SHIFT_RD = 3'd5;
    localparam logic [2:0] S_SHIFT_WR = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic             found_reg;
    logic             found_next;
    tsm_pkg::status_t status_reg;
    tsm_pkg::status_t status_next;

    // Sequence one transaction at a time
    always_comb
    begin
        state_next  = state_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                found_next  = 1'b0;
                status_next = tsm_pkg::STATUS_OK;
                priority if (!stat.enabled)
                begin
                    found_next = stat.is_query;
                    state_next = S_DONE;
                end
                else if (stat.is_query)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SEARCH;
                end
                else if (stat.zoom_bad)
                begin
                    status_next = tsm_pkg::STATUS_ZOOM;
                    state_next  = S_DONE;
                end
                else if (stat.range_bad)
                begin
                    status_next = tsm_pkg::STATUS_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.search_init = 1'b1;
                    state_next      = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_more)
                begin
                    cmd.search_rd = 1'b1;
                    state_next    = S_CMP;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP:
            begin
                cmd.search_upd = 1'b1;
                state_next     = S_SEARCH;
            end
            S_DECIDE:
            begin
                priority if (stat.is_query)
                begin
                    found_next = stat.hit;
                    state_next = S_DONE;
                end
                else if (stat.hit)
                begin
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    status_next = tsm_pkg::STATUS_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next     = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.res_found  = found_reg;
        cmd.res_status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            status_reg <= tsm_pkg::STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire
